// ----- rtl/swre_pkg.sv -----
`default_nettype none

package swre_pkg;

    // Field widths.
    localparam int BLK_W    = 31;
    localparam int SEC_W    = 32;
    localparam int DIFF_W   = 32;
    localparam int WEIGHT_W = 18;
    localparam int WS_W     = 11;
    localparam int TIME_W   = 33;
    localparam int WORK_W   = 50;
    localparam int WTOT_W   = 28;
    localparam int KTOT_W   = 60;
    localparam int W17_W    = 29;
    localparam int K17_W    = 61;
    localparam int RATE_W   = 48;

    // Rate divider widths: the divisor is weight * span, scaled up by 2^13.
    localparam int DEN_W     = W17_W + TIME_W;
    localparam int DEN_SHIFT = 13;
    localparam int REM_W     = DEN_W + DEN_SHIFT;

    // 4.295032833 in Q.29.
    localparam logic [31:0] RATE_CONST = 32'd2305878194;

    localparam int MAX_WINDOW_DEF = 1024;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BLOCK = 2'd1;
    localparam logic [WS_W-1:0]      WINDOW_RESET    = 11'd432;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [WEIGHT_W-1:0] weight;
        logic [WORK_W-1:0]   work;
    } t_slot;

    typedef struct packed {
        logic [K17_W-1:0]  k17;
        logic [W17_W-1:0]  w17;
        logic [TIME_W-1:0] span;
    } t_rate_op;

    typedef struct packed {
        logic [TIME_W-1:0] mid_time;
        logic [TIME_W-1:0] begin_time;
        logic [TIME_W-1:0] end_time;
        logic [W17_W-1:0]  window_weight;
        logic [K17_W-1:0]  window_work;
        logic [RATE_W-1:0] rate;
        logic              divide_fault;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SUB,
        ST_ADD,
        ST_WRAP1,
        ST_WRAP2,
        ST_CHECK,
        ST_RATE,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        RS_IDLE,
        RS_NC,
        RS_LL,
        RS_LH,
        RS_HL,
        RS_HH,
        RS_DEN,
        RS_DENADD,
        RS_NUM,
        RS_SAT,
        RS_DIV,
        RS_DONE
    } t_rate_state;

endpackage

`default_nettype wire

// ----- rtl/sliding_window_rate_estimator.sv -----
// Sliding window rate estimator.
// Input channel (i_valid/o_ready) takes one event beat: block number, start and
// stop time, difficulty and weight. Output channel (o_valid/i_ready) gives one
// result beat each time the ring write position wraps to zero.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_data) and must
// only be used while the block is idle: index 0 is the window size, index 1 the
// start block.
// After reset the block runs a clearing pass over all MAX_WINDOW ring entries,
// and o_ready stays low until it ends.
// An event that does not wrap the ring goes through the ring memory read, the two
// total updates and the pointer step before o_ready returns. An event that wraps
// goes on through the rate unit: a shared 32x32 multiplier builds numerator and
// divisor, one compare checks for saturation, and a shared compare-and-subtract
// makes one quotient bit per cycle. A saturated rate skips the division, and a
// divide fault skips the rate unit altogether.
// The result is held in an output register; when the receiver stalls, later
// events are still taken, and a new result waits until the old one has left.
`default_nettype none

module sliding_window_rate_estimator #(
    parameter int MAX_WINDOW = swre_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [swre_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [swre_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // event input
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [swre_pkg::BLK_W-1:0]         i_block_number,
    input  logic [swre_pkg::SEC_W-1:0]         i_start_time,
    input  logic [swre_pkg::SEC_W-1:0]         i_stop_time,
    input  logic [swre_pkg::DIFF_W-1:0]        i_difficulty,
    input  logic [swre_pkg::WEIGHT_W-1:0]      i_weight,
    // result output
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [swre_pkg::TIME_W-1:0]        o_mid_time,
    output logic [swre_pkg::TIME_W-1:0]        o_begin_time,
    output logic [swre_pkg::TIME_W-1:0]        o_end_time,
    output logic [swre_pkg::W17_W-1:0]         o_window_weight,
    output logic [swre_pkg::K17_W-1:0]         o_window_work,
    output logic [swre_pkg::RATE_W-1:0]        o_rate,
    output logic                               o_divide_fault
);
    import swre_pkg::*;

    localparam int ALEN  = $clog2(MAX_WINDOW);
    localparam int CNT_W = ALEN + 1;
    localparam logic [ALEN-1:0] CLR_LAST = ALEN'(MAX_WINDOW - 1);

    // The ring: sum of start and stop time, weight and work of each event in the window.
    t_slot ring_mem [MAX_WINDOW];

    t_state               r_state, n_state;
    logic [WS_W-1:0]      r_window_size;
    logic [BLK_W-1:0]     r_start_block;
    logic                 r_started;
    logic [ALEN-1:0]      r_pos;
    logic [ALEN-1:0]      r_clr;
    logic [WTOT_W-1:0]    r_wt;
    logic [KTOT_W-1:0]    r_kt;
    t_slot                r_slot0;
    t_slot                r_old;
    logic                 r_out_valid;
    t_result              r_out;

    logic [TIME_W-1:0]    r_time;
    logic [WEIGHT_W-1:0]  r_w;
    logic [DIFF_W-1:0]    r_diff;
    logic [WORK_W-1:0]    r_k;
    logic [TIME_W-1:0]    r_begin, r_end, r_span, r_mid;
    logic                 r_end_gt;
    logic [WEIGHT_W:0]    r_wsub;
    logic [WORK_W:0]      r_ksub;
    logic [W17_W-1:0]     r_w17;
    logic [K17_W-1:0]     r_k17;
    logic                 r_fault;

    logic [CNT_W-1:0]     win_n;
    logic [ALEN-1:0]      win_nm1;
    logic [CNT_W-1:0]     pos_inc;
    logic                 pos_wrap;
    logic                 in_beat;
    logic                 mem_we;
    logic [ALEN-1:0]      mem_addr;
    t_slot                mem_wdata;
    t_slot                new_slot;
    logic                 rate_start;
    logic                 rate_done;
    logic [RATE_W-1:0]    rate_q;
    t_rate_op             rate_op;
    logic                 out_load;
    logic                 fault_now;
    logic [W17_W:0]       w_diff;
    logic [K17_W:0]       k_diff;
    logic [TIME_W:0]      mid_sum;

    // Window length, held inside 2..MAX_WINDOW.
    always_comb begin
        if (r_window_size < WS_W'(2)) begin
            win_n = CNT_W'(2);
        end else if (32'(r_window_size) > 32'(MAX_WINDOW)) begin
            win_n = CNT_W'(MAX_WINDOW);
        end else begin
            win_n = CNT_W'(r_window_size);
        end
    end

    assign win_nm1  = ALEN'(win_n - 1'b1);
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    // A shrunk window can leave the pointer past its end; it wraps then too.
    assign pos_wrap = (pos_inc >= win_n);

    assign o_ready  = (r_state == ST_IDLE);
    assign in_beat  = i_valid && o_ready;
    assign new_slot = '{stamp: r_time, weight: r_w, work: r_k};

    assign fault_now = (r_w17 == '0) || !r_end_gt;

    assign w_diff  = {1'b0, r_wt, 1'b0} - (W17_W+1)'(r_wsub);
    assign k_diff  = {1'b0, r_kt, 1'b0} - (K17_W+1)'(r_ksub);
    assign mid_sum = {1'b0, r_begin} + {1'b0, r_end};

    always_comb begin
        n_state    = r_state;
        mem_we     = 1'b0;
        mem_addr   = r_pos;
        mem_wdata  = new_slot;
        rate_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                if (r_clr == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE:  if (i_valid && r_started) n_state = ST_READ;
            ST_READ:  n_state = ST_SUB;
            ST_SUB: begin
                mem_we  = 1'b1;
                n_state = ST_ADD;
            end
            ST_ADD:   n_state = pos_wrap ? ST_WRAP1 : ST_IDLE;
            ST_WRAP1: n_state = ST_WRAP2;
            ST_WRAP2: n_state = ST_CHECK;
            ST_CHECK: begin
                if (fault_now) begin
                    n_state = ST_EMIT;
                end else begin
                    rate_start = 1'b1;
                    n_state    = ST_RATE;
                end
            end
            ST_RATE:  if (rate_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring memory: one write port, one registered read at the write pointer.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        r_old <= ring_mem[r_pos];
    end

    // Control state and running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_RESET;
            r_start_block <= '0;
            r_started     <= 1'b0;
            r_pos         <= '0;
            r_clr         <= '0;
            r_wt          <= '0;
            r_kt          <= '0;
            r_slot0       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_WINDOW_SIZE: r_window_size <= i_cfg_data[WS_W-1:0];
                    REG_START_BLOCK: r_start_block <= i_cfg_data[BLK_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // The start test applies from the next event on.
            if (in_beat && !r_started) begin
                r_started <= (i_block_number >= r_start_block);
            end
            if (r_state == ST_SUB) begin
                r_wt <= r_wt - WTOT_W'(r_old.weight) + WTOT_W'(r_w);
                r_kt <= r_kt - KTOT_W'(r_old.work);
                if (r_pos == '0) begin
                    r_slot0 <= new_slot;
                end
            end
            if (r_state == ST_ADD) begin
                r_kt  <= r_kt + KTOT_W'(r_k);
                r_pos <= pos_wrap ? '0 : pos_inc[ALEN-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Event and window payload.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_time <= TIME_W'(i_start_time) + TIME_W'(i_stop_time);
            r_w    <= i_weight;
            r_diff <= i_difficulty;
        end
        if (r_state == ST_READ) begin
            r_k <= WORK_W'(r_diff) * WORK_W'(r_w);
        end
        if (r_state == ST_WRAP1) begin
            r_begin  <= r_slot0.stamp;
            r_end    <= r_time;
            r_span   <= r_time - r_slot0.stamp;
            r_end_gt <= (r_time > r_slot0.stamp);
            r_wsub   <= (WEIGHT_W+1)'(r_slot0.weight) + (WEIGHT_W+1)'(r_w);
            r_ksub   <= (WORK_W+1)'(r_slot0.work) + (WORK_W+1)'(r_k);
        end
        if (r_state == ST_WRAP2) begin
            // The oldest and newest entries count half; clamp at zero.
            r_w17 <= w_diff[W17_W] ? '0 : w_diff[W17_W-1:0];
            r_k17 <= k_diff[K17_W] ? '0 : k_diff[K17_W-1:0];
            r_mid <= mid_sum[TIME_W:1];
        end
        if (r_state == ST_CHECK) begin
            r_fault <= fault_now;
        end
        if (out_load) begin
            r_out.mid_time      <= r_mid;
            r_out.begin_time    <= r_begin;
            r_out.end_time      <= r_end;
            r_out.window_weight <= r_w17;
            r_out.window_work   <= r_k17;
            r_out.rate          <= r_fault ? '0 : rate_q;
            r_out.divide_fault  <= r_fault;
        end
    end

    assign rate_op = '{k17: r_k17, w17: r_w17, span: r_span};

    swre_rate #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rate_start),
        .i_op    (rate_op),
        .i_nm1   (win_nm1),
        .o_done  (rate_done),
        .o_rate  (rate_q)
    );

    assign o_valid         = r_out_valid;
    assign o_mid_time      = r_out.mid_time;
    assign o_begin_time    = r_out.begin_time;
    assign o_end_time      = r_out.end_time;
    assign o_window_weight = r_out.window_weight;
    assign o_window_work   = r_out.window_work;
    assign o_rate          = r_out.rate;
    assign o_divide_fault  = r_out.divide_fault;

`ifndef SYNTHESIS
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> r_state == ST_CLEAR)
        else $error("clearing pass did not start after reset");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result raised outside the emit step");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rate_done |-> r_state == ST_RATE)
        else $error("rate unit finished while nobody waited");

    a_fault_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.divide_fault) |-> r_out.rate == '0)
        else $error("faulted result carries a nonzero rate");
`endif

endmodule

`default_nettype wire

// ----- rtl/swre_rate.sv -----
`default_nettype none

module swre_rate #(
    parameter int MAX_WINDOW = swre_pkg::MAX_WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  swre_pkg::t_rate_op                i_op,
    input  logic [$clog2(MAX_WINDOW)-1:0]     i_nm1,
    output logic                              o_done,
    output logic [swre_pkg::RATE_W-1:0]       o_rate
);
    import swre_pkg::*;

    localparam int ALEN  = $clog2(MAX_WINDOW);
    localparam int M_W   = ALEN + 32;
    localparam int ACC_W = K17_W + M_W;
    localparam int NUM_W = ACC_W + 2;
    localparam int CNT_W = $clog2(RATE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATE_W - 1);

    t_rate_state       r_state, n_state;
    logic [63:0]       r_prod;
    logic [M_W-1:0]    r_m;
    logic [ACC_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [RATE_W-1:0] r_q;
    logic [CNT_W-1:0]  r_cnt;

    logic [31:0]       k_lo, k_hi, m_hi;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [REM_W-1:0]  den2;
    logic [REM_W:0]    cmp_a;
    logic [REM_W+1:0]  cmp_d;
    logic              ge;

    assign k_lo = i_op.k17[31:0];
    assign k_hi = 32'(i_op.k17[K17_W-1:32]);
    assign m_hi = 32'(r_m[M_W-1:32]);

    // One 32x32 multiplier, reused for every partial product.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            RS_NC: begin
                mul_a = 32'(i_nm1);
                mul_b = RATE_CONST;
            end
            RS_LL: begin
                mul_a = k_lo;
                mul_b = r_prod[31:0];
            end
            RS_LH: begin
                mul_a = k_lo;
                mul_b = m_hi;
            end
            RS_HL: begin
                mul_a = k_hi;
                mul_b = r_m[31:0];
            end
            RS_HH: begin
                mul_a = k_hi;
                mul_b = m_hi;
            end
            RS_DEN: begin
                mul_a = 32'(i_op.w17);
                mul_b = i_op.span[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // One compare-and-subtract, used for the saturation test and every quotient bit.
    assign den2  = {r_den, {DEN_SHIFT{1'b0}}};
    assign cmp_a = (r_state == RS_SAT) ? (REM_W+1)'(r_num[NUM_W-1:RATE_W])
                                       : {r_rem, r_q[RATE_W-1]};
    assign cmp_d = {1'b0, cmp_a} - {2'b00, den2};
    assign ge    = ~cmp_d[REM_W+1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RS_IDLE:   if (i_start) n_state = RS_NC;
            RS_NC:     n_state = RS_LL;
            RS_LL:     n_state = RS_LH;
            RS_LH:     n_state = RS_HL;
            RS_HL:     n_state = RS_HH;
            RS_HH:     n_state = RS_DEN;
            RS_DEN:    n_state = RS_DENADD;
            RS_DENADD: n_state = RS_NUM;
            RS_NUM:    n_state = RS_SAT;
            RS_SAT:    n_state = ge ? RS_DONE : RS_DIV;
            RS_DIV:    if (r_cnt == CNT_LAST) n_state = RS_DONE;
            RS_DONE:   n_state = RS_IDLE;
            default:   n_state = RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state) inside
            RS_LL: begin
                r_m   <= M_W'(r_prod);
                r_acc <= '0;
            end
            RS_LH: r_acc <= r_acc + ACC_W'(r_prod);
            RS_HL, RS_HH: r_acc <= r_acc + (ACC_W'(r_prod) << 32);
            RS_DEN: r_acc <= r_acc + (ACC_W'(r_prod) << 64);
            RS_DENADD: begin
                r_den <= DEN_W'(r_prod)
                       + (i_op.span[TIME_W-1] ? (DEN_W'(i_op.w17) << 32) : '0);
            end
            RS_NUM: begin
                // Adding half the divisor makes the truncating division round.
                r_num <= (NUM_W'(r_acc) << 1) + (NUM_W'(r_den) << (DEN_SHIFT - 1));
            end
            RS_SAT: begin
                if (ge) begin
                    r_q <= '1;
                end else begin
                    r_rem <= REM_W'(r_num[NUM_W-1:RATE_W]);
                    r_q   <= r_num[RATE_W-1:0];
                    r_cnt <= '0;
                end
            end
            RS_DIV: begin
                r_rem <= ge ? cmp_d[REM_W-1:0] : cmp_a[REM_W-1:0];
                r_q   <= {r_q[RATE_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == RS_DONE);
    assign o_rate = r_q;

endmodule

`default_nettype wire

// ----- sim/sliding_window_rate_checker.sv -----
module sliding_window_rate_checker
    import swre_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_ev_valid,
    input  logic                  i_ev_ready,
    input  logic [BLK_W-1:0]      i_block_number,
    input  logic [SEC_W-1:0]      i_start_time,
    input  logic [SEC_W-1:0]      i_stop_time,
    input  logic [DIFF_W-1:0]     i_difficulty,
    input  logic [WEIGHT_W-1:0]   i_weight,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [TIME_W-1:0]     i_mid_time,
    input  logic [TIME_W-1:0]     i_begin_time,
    input  logic [TIME_W-1:0]     i_end_time,
    input  logic [W17_W-1:0]      i_window_weight,
    input  logic [K17_W-1:0]      i_window_work,
    input  logic [RATE_W-1:0]     i_rate,
    input  logic                  i_divide_fault,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results
);

    localparam logic [127:0] RATE_CEIL = 128'({RATE_W{1'b1}});
    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the ring, the running sums and the two registers.
    logic [TIME_W-1:0]   slot_time   [MAX_WINDOW];
    logic [WEIGHT_W-1:0] slot_weight [MAX_WINDOW];
    logic [WORK_W-1:0]   slot_work   [MAX_WINDOW];
    logic [WTOT_W-1:0]   weight_sum;
    logic [KTOT_W-1:0]   work_sum;
    int unsigned         wr_pos;
    logic                running;
    logic [WS_W-1:0]     ring_len_reg;
    logic [BLK_W-1:0]    start_blk_reg;

    t_result due_windows[$];
    int      bad_fields;
    int      windows_checked;

    // Rounded, saturated Q32.16 rate from the integer window sums.
    function automatic logic [RATE_W-1:0] scaled_rate(
        input logic [K17_W-1:0]  work17,
        input int unsigned       len_less_one,
        input logic [W17_W-1:0]  weight17,
        input logic [TIME_W-1:0] span
    );
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quot;
        denom = (128'(weight17) * 128'(span)) << 12;
        numer = ((128'(work17) * 128'(len_less_one) * 128'(RATE_CONST)) << 1) + denom;
        quot = numer / (denom << 1);
        if (quot > RATE_CEIL) begin
            scaled_rate = '1;
        end else begin
            scaled_rate = quot[RATE_W-1:0];
        end
    endfunction

    task automatic absorb_event(
        input logic [BLK_W-1:0]    blk,
        input logic [SEC_W-1:0]    t_start,
        input logic [SEC_W-1:0]    t_stop,
        input logic [DIFF_W-1:0]   diff,
        input logic [WEIGHT_W-1:0] w
    );
        int unsigned        n;
        int unsigned        p;
        int unsigned        nxt;
        logic [WORK_W-1:0]  k;
        logic [TIME_W-1:0]  t_begin;
        logic [TIME_W-1:0]  t_end;
        logic [TIME_W:0]    t_pair;
        logic [W17_W-1:0]   w_two;
        logic [W17_W-1:0]   w_cut;
        logic [K17_W-1:0]   k_two;
        logic [K17_W-1:0]   k_cut;
        t_result            summary;
        if (running) begin
            n = 32'(ring_len_reg);
            if (n < 2) n = 2;
            if (n > MAX_WINDOW) n = MAX_WINDOW;
            p = wr_pos;
            k = WORK_W'(diff) * WORK_W'(w);

            weight_sum = weight_sum - WTOT_W'(slot_weight[p]) + WTOT_W'(w);
            work_sum = work_sum - KTOT_W'(slot_work[p]) + KTOT_W'(k);
            slot_time[p] = TIME_W'(t_start) + TIME_W'(t_stop);
            slot_weight[p] = w;
            slot_work[p] = k;

            // A shrunk window wraps on the next write, wherever the pointer is.
            nxt = p + 1;
            if (nxt >= n) nxt = 0;
            wr_pos = nxt;

            if (nxt == 0) begin
                t_begin = slot_time[0];
                t_end = slot_time[p];
                t_pair = (TIME_W+1)'(t_begin) + (TIME_W+1)'(t_end);
                w_two = {weight_sum, 1'b0};
                w_cut = W17_W'(slot_weight[0]) + W17_W'(slot_weight[p]);
                k_two = {work_sum, 1'b0};
                k_cut = K17_W'(slot_work[0]) + K17_W'(slot_work[p]);

                summary.mid_time = t_pair[TIME_W:1];
                summary.begin_time = t_begin;
                summary.end_time = t_end;
                summary.window_weight = (w_two >= w_cut) ? w_two - w_cut : '0;
                summary.window_work = (k_two >= k_cut) ? k_two - k_cut : '0;
                if (summary.window_weight == '0 || t_end <= t_begin) begin
                    summary.rate = '0;
                    summary.divide_fault = 1'b1;
                end else begin
                    summary.rate = scaled_rate(summary.window_work, n - 1,
                                               summary.window_weight, t_end - t_begin);
                    summary.divide_fault = 1'b0;
                end
                due_windows.push_back(summary);
            end
        end
        if (blk >= start_blk_reg) running = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            bad_fields++;
            if (bad_fields <= REPORT_LIMIT) begin
                $display("%0t: %0s mismatch on window %0d: expected %h, got %h",
                         $time, name, windows_checked, want, got);
            end
        end
    endtask

    task automatic retire_window();
        t_result want;
        if (due_windows.size() == 0) begin
            bad_fields++;
            if (bad_fields <= REPORT_LIMIT) begin
                $display("%0t: result beat arrived with no window due: rate %h",
                         $time, i_rate);
            end
        end else begin
            want = due_windows.pop_front();
            check_field("mid_time", 64'(want.mid_time), 64'(i_mid_time));
            check_field("begin_time", 64'(want.begin_time), 64'(i_begin_time));
            check_field("end_time", 64'(want.end_time), 64'(i_end_time));
            check_field("window_weight", 64'(want.window_weight), 64'(i_window_weight));
            check_field("window_work", 64'(want.window_work), 64'(i_window_work));
            check_field("rate", 64'(want.rate), 64'(i_rate));
            check_field("divide_fault", 64'(want.divide_fault), 64'(i_divide_fault));
            windows_checked++;
        end
    endtask

    initial begin
        bad_fields = 0;
        windows_checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                slot_time[i] = '0;
                slot_weight[i] = '0;
                slot_work[i] = '0;
            end
            weight_sum = '0;
            work_sum = '0;
            wr_pos = 0;
            running = 1'b0;
            ring_len_reg = WINDOW_RESET;
            start_blk_reg = '0;
            due_windows.delete();
        end else begin
            if (i_res_valid && i_res_ready) retire_window();
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_WINDOW_SIZE: ring_len_reg = i_cfg_data[WS_W-1:0];
                    REG_START_BLOCK: start_blk_reg = i_cfg_data[BLK_W-1:0];
                    default: ;
                endcase
            end
            if (i_ev_valid && i_ev_ready) begin
                absorb_event(i_block_number, i_start_time, i_stop_time, i_difficulty,
                             i_weight);
            end
        end
        o_pending <= due_windows.size();
        o_fail_count <= bad_fields;
        o_results <= windows_checked;
    end

endmodule

// ----- sim/sliding_window_rate_estimator_test.sv -----
module sliding_window_rate_estimator_test;
    import swre_pkg::*;

    // Clock is 12 time units per period; reset is held at the start of the run.
    localparam int     CLK_HALF        = 6;
    localparam int     RESET_CYCLES    = 3;
    // A wrapping event takes far longer than a plain one, most of it in the rate
    // unit. Before touching a register we wait well past that.
    localparam int     SETTLE_CYCLES   = 150;
    localparam int     RANDOM_PHASES   = 16;
    localparam int     BIG_PHASE_AFTER = 9;
    // Enough beats for a full 1024-entry window to wrap once from any start.
    localparam int     BIG_PHASE_BEATS = 1030;
    localparam int     MAX_WINDOW      = MAX_WINDOW_DEF;
    // Run time limit, many times the slowest legal run.
    localparam longint RUN_LIMIT       = 24_000_000;

    // The config port has two spare indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {
        MIX_NONE,
        MIX_SOURCE,
        MIX_SINK,
        MIX_BOTH
    } t_idle_mix;

    typedef struct {
        logic [BLK_W-1:0]    blk;
        logic [SEC_W-1:0]    t_start;
        logic [SEC_W-1:0]    t_stop;
        logic [DIFF_W-1:0]   diff;
        logic [WEIGHT_W-1:0] w;
    } t_event_beat;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [BLK_W-1:0]      i_block_number  = '0;
    logic [SEC_W-1:0]      i_start_time    = '0;
    logic [SEC_W-1:0]      i_stop_time     = '0;
    logic [DIFF_W-1:0]     i_difficulty    = '0;
    logic [WEIGHT_W-1:0]   i_weight        = '0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic [TIME_W-1:0]     o_mid_time;
    logic [TIME_W-1:0]     o_begin_time;
    logic [TIME_W-1:0]     o_end_time;
    logic [W17_W-1:0]      o_window_weight;
    logic [K17_W-1:0]      o_window_work;
    logic [RATE_W-1:0]     o_rate;
    logic                  o_divide_fault;

    int          fail_count;
    int          pending_windows;
    int          windows_checked;
    int          sent_beats      = 0;
    int          src_idle_pct    = 0;
    int          sink_stall_pct  = 0;
    // Running event clock for well-formed random traffic, in seconds.
    logic [31:0] time_base;

    sliding_window_rate_estimator #(
        .MAX_WINDOW(MAX_WINDOW)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_block_number(i_block_number),
        .i_start_time(i_start_time),
        .i_stop_time(i_stop_time),
        .i_difficulty(i_difficulty),
        .i_weight(i_weight),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_mid_time(o_mid_time),
        .o_begin_time(o_begin_time),
        .o_end_time(o_end_time),
        .o_window_weight(o_window_weight),
        .o_window_work(o_window_work),
        .o_rate(o_rate),
        .o_divide_fault(o_divide_fault)
    );

    sliding_window_rate_checker #(
        .MAX_WINDOW(MAX_WINDOW)
    ) rate_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .i_ev_valid(i_valid),
        .i_ev_ready(o_ready),
        .i_block_number(i_block_number),
        .i_start_time(i_start_time),
        .i_stop_time(i_stop_time),
        .i_difficulty(i_difficulty),
        .i_weight(i_weight),
        .i_res_valid(o_valid),
        .i_res_ready(i_ready),
        .i_mid_time(o_mid_time),
        .i_begin_time(o_begin_time),
        .i_end_time(o_end_time),
        .i_window_weight(o_window_weight),
        .i_window_work(o_window_work),
        .i_rate(o_rate),
        .i_divide_fault(o_divide_fault),
        .o_fail_count(fail_count),
        .o_pending(pending_windows),
        .o_results(windows_checked)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // The receiver decides once per cycle, at the falling edge, whether to stall.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_idle_mix(input t_idle_mix mix);
        case (mix)
            MIX_NONE: begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            MIX_SOURCE: begin
                src_idle_pct = 46;
                sink_stall_pct = 0;
            end
            MIX_SINK: begin
                src_idle_pct = 0;
                sink_stall_pct = 46;
            end
            default: begin
                src_idle_pct = 8;
                sink_stall_pct = 8;
            end
        endcase
    endtask

    function automatic t_event_beat make_event(
        input logic [BLK_W-1:0]    blk,
        input logic [SEC_W-1:0]    t_start,
        input logic [SEC_W-1:0]    t_stop,
        input logic [DIFF_W-1:0]   diff,
        input logic [WEIGHT_W-1:0] w
    );
        t_event_beat ev;
        ev.blk = blk;
        ev.t_start = t_start;
        ev.t_stop = t_stop;
        ev.diff = diff;
        ev.w = w;
        return ev;
    endfunction

    // Mostly advancing times so spans are positive, with a few wild stamps
    // that give backward spans and divide faults. Difficulty and weight lean
    // on zero, all ones and small values on top of full-range draws.
    function automatic t_event_beat random_event();
        t_event_beat ev;
        logic [31:0] r;
        int unsigned pick;
        r = $urandom();
        ev.blk = r[BLK_W-1:0];
        pick = $urandom_range(99);
        if (pick < 5) begin
            ev.t_start = $urandom();
            ev.t_stop = $urandom();
        end else begin
            time_base = time_base + $urandom_range(0, 600);
            ev.t_start = time_base;
            ev.t_stop = time_base + $urandom_range(0, 300);
        end
        pick = $urandom_range(99);
        if (pick < 10) ev.diff = '0;
        else if (pick < 20) ev.diff = '1;
        else if (pick < 35) ev.diff = $urandom_range(0, 1000);
        else ev.diff = $urandom();
        pick = $urandom_range(99);
        r = $urandom();
        if (pick < 8) ev.w = '0;
        else if (pick < 14) ev.w = '1;
        else if (pick < 30) ev.w = WEIGHT_W'($urandom_range(1, 16));
        else ev.w = r[WEIGHT_W-1:0];
        return ev;
    endfunction

    // One beat on the event channel. Valid goes up at a falling edge and stays
    // up with the payload held until a rising edge sees ready.
    task automatic send_event(input t_event_beat ev);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_block_number <= ev.blk;
        i_start_time <= ev.t_start;
        i_stop_time <= ev.t_stop;
        i_difficulty <= ev.diff;
        i_weight <= ev.w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_beats++;
    endtask

    task automatic send_random(input int beats);
        for (int i = 0; i < beats; i++) begin
            send_event(random_event());
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every due window to come out, then give the block
    // time to finish any event that produces no result.
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_windows != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [31:0]     r;
        logic [WS_W-1:0] win;
        int              beats;

        time_base = $urandom();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The highest start threshold is set first so that only
        // the top block number opens the window; a window size of zero must
        // behave as two, and the spare indexes must change nothing.
        set_idle_mix(MIX_NONE);
        write_reg(REG_START_BLOCK, '1);
        write_reg(REG_WINDOW_SIZE, '0);
        r = $urandom();
        write_reg(REG_SPARE_A, r[CFG_DATA_W-1:0]);
        write_reg(REG_SPARE_B, '1);

        // Below the threshold, one under it, then exactly on it. None of these
        // enter the ring; the last one arms it for the next event.
        send_event(make_event('0, '1, '1, '1, '1));
        send_event(make_event(31'h7FFF_FFFE, '0, '0, '0, '0));
        send_event(make_event('1, '0, '1, '1, '0));

        // All-zero event then all-ones event: widest possible span.
        send_event(make_event('0, '0, '0, '0, '0));
        send_event(make_event('1, '1, '1, '1, '1));
        // Equal stamps give a zero span and must flag a divide fault.
        send_event(make_event(31'd5, 32'd100, 32'd100, 32'd7, 18'h10000));
        send_event(make_event(31'd6, 32'd100, 32'd100, 32'd7, 18'h10000));
        // A window that runs backward in time faults as well.
        send_event(make_event(31'd7, 32'd500, 32'd500, 32'd9, 18'h08000));
        send_event(make_event(31'd8, 32'd400, 32'd400, 32'd9, 18'h08000));
        // Zero total weight faults even with a good span.
        send_event(make_event(31'd9, 32'd1000, 32'd1000, '1, '0));
        send_event(make_event(31'd10, 32'd1001, 32'd1001, '1, '0));
        // Huge work over a tiny weight and a one-half-second span saturates.
        send_event(make_event(31'd11, 32'd10, 32'd10, '1, 18'd1));
        send_event(make_event(31'd12, 32'd10, 32'd11, '1, 18'd1));
        // An ordinary window with a modest rate.
        send_event(make_event(31'd13, 32'd2000, 32'd2001, 32'd123456, 18'h10000));
        send_event(make_event(31'd14, 32'd2010, 32'd2012, 32'd654321, 18'h20000));
        drain_and_settle();

        // Shrinking the window under the write pointer: five events into a
        // window of sixteen, then a size of three must wrap on the next write.
        write_reg(REG_WINDOW_SIZE, 31'd16);
        write_reg(REG_START_BLOCK, '0);
        send_random(5);
        drain_and_settle();
        write_reg(REG_WINDOW_SIZE, 31'd3);
        send_event(random_event());
        drain_and_settle();

        // Random part. Each phase picks a window size and an idle mix; the
        // pointer is left wherever the previous phase stopped, so shrinks and
        // partial windows come up on their own. The oversized setting only
        // advances the pointer, and the small window after it wraps at once.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idle_mix(t_idle_mix'(ph % 4));
            case (ph)
                0: win = 11'd1;
                1: win = 11'd2;
                2: win = '1;
                default: begin
                    r = $urandom_range(2, 12);
                    win = r[WS_W-1:0];
                end
            endcase
            write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
            if (ph % 5 == 4) begin
                r = $urandom();
                write_reg(REG_START_BLOCK, r[CFG_DATA_W-1:0]);
            end
            beats = (ph == 2) ? 15 : $urandom_range(6, 16);
            send_random(beats);
            drain_and_settle();

            // One full pass of the largest ring.
            if (ph == BIG_PHASE_AFTER) begin
                set_idle_mix(MIX_SINK);
                write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(MAX_WINDOW));
                send_random(BIG_PHASE_BEATS);
                drain_and_settle();
            end
        end

        $display("Run covered %0d event beats and %0d window results,", sent_beats,
                 windows_checked);
        $display("with window sizes from 0 to 2047, faults, saturation and all idle mixes.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
